// File: design/sha_pkg.sv
// shared types and constants for the sha-256 stream hasher
package sha_pkg;

    typedef logic [31:0] t_word;

    // command from front to back part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       is_last;
    } t_cmd;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic t_word ror32(input t_word v, input int amt);
        ror32 = (v >> amt) | (v << (32 - amt));
    endfunction

endpackage

// File: design/sha_front.sv
// input side: drops empty non-last items and queues commands for the core
module sha_front
    import sha_pkg::*;
#(
    parameter int DEPTH_LOG2 = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_carries_byte,
    input  logic       i_is_last,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_take
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_cmd                r_q [DEPTH];
    logic [DEPTH_LOG2:0] r_wr, r_rd;
    logic                full, push, keep;

    assign full        = (r_wr[DEPTH_LOG2] != r_rd[DEPTH_LOG2]) &&
                         (r_wr[DEPTH_LOG2-1:0] == r_rd[DEPTH_LOG2-1:0]);
    assign o_stall     = full;
    assign keep        = i_carries_byte | i_is_last;
    assign push        = i_valid && !full && keep;
    assign o_cmd_valid = (r_wr != r_rd);
    assign o_cmd       = r_q[r_rd[DEPTH_LOG2-1:0]];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr[DEPTH_LOG2-1:0]] <= '{i_data_byte, i_carries_byte, i_is_last};
        end
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_cmd_take && o_cmd_valid) r_rd <= r_rd + 1'b1;
        end
    end
endmodule

// File: design/sha_core.sv
// back side: block buffer, padding, round engine and digest output
module sha_core
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_ROUND = 3'd2,
                           S_ADD = 3'd3, S_OUT = 3'd4;

    logic [2:0]  r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];    // block words while filling, schedule window in rounds
    logic [5:0]  r_rnd;
    logic        r_closing;   // message is being closed
    logic        r_marked;    // pad byte already placed
    logic        r_len_blk;   // block being padded carries the length
    logic        r_final;     // block in flight is the one holding the length
    logic [2:0]  r_oidx;

    t_word      wt, s0, s1, b1, ch, t1, b0, mj, w15, w2;
    logic       take;
    logic [5:0] n_fill;
    logic [7:0] pad_byte;
    logic [7:0] wr_byte;
    logic       wr_en;

    assign take       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_take = take;
    assign n_fill     = (take && i_cmd.carries_byte) ? r_fill + 6'd1 : r_fill;

    always_comb begin
        w15 = r_w[1];
        w2  = r_w[14];
        s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
        s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
        wt  = (r_rnd < 6'd16) ? r_w[0] : r_w[0] + s0 + r_w[9] + s1;
        b1  = ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + b1 + ch + ROUND_K[r_rnd] + wt;
        b0  = ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    // padding is written one byte per cycle from the fill position
    always_comb begin
        priority if (!r_marked) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_blk && r_fill >= LEN_POS) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
        wr_en   = (r_state == S_PAD) || (take && i_cmd.carries_byte);
        wr_byte = (r_state == S_PAD) ? pad_byte : i_cmd.data_byte;
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_closing <= 1'b0;
            r_marked  <= 1'b0;
            r_len_blk <= 1'b0;
            r_final   <= 1'b0;
            r_oidx    <= '0;
            r_rnd     <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
        end else begin
            if (wr_en) begin
                r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_byte;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_closing <= i_cmd.is_last;
                        r_marked  <= 1'b0;
                        r_final   <= 1'b0;
                        r_len_blk <= (n_fill < LEN_POS);
                        r_fill    <= n_fill;
                        if (i_cmd.carries_byte) r_bits <= r_bits + 64'd8;
                        if (i_cmd.carries_byte && r_fill == 6'd63) begin
                            r_state <= S_ROUND;
                            r_rnd   <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end else if (i_cmd.is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_marked <= 1'b1;
                    r_fill   <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_state <= S_ROUND;
                        r_rnd   <= '0;
                        r_final <= r_len_blk;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + b0 + mj;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wt;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (!r_closing) begin
                        r_state <= S_IDLE;
                    end else if (r_final) begin
                        r_state <= S_OUT;
                        r_oidx  <= '0;
                    end else begin
                        // another padding block follows, ending with the length
                        r_state   <= S_PAD;
                        r_len_blk <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state   <= S_IDLE;
                            r_fill    <= '0;
                            r_bits    <= '0;
                            r_closing <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher
//
// input channel: one item per message byte (i_data_byte, i_carries_byte,
// i_is_last), accepted when i_valid is high and o_stall is low. an item
// without a byte and not last is dropped. the item marked last closes the
// message; an item with no byte and last closes an empty message.
// output channel: eight items per message, h0 first, with o_word_index
// and o_last_word on h7, taken when o_valid is high and i_stall is low.
// a four-entry command queue parts the input from the hashing core.
// the core takes one byte at a time while idle; every 64th byte starts
// the 64 one-per-cycle rounds and the chaining add. closing writes
// the padding one byte per cycle up to the block end, then the rounds
// and add follow; with 56 or more bytes in the last block a second
// padding block follows. the eight output words come last.
// no byte is taken while the rounds run; this loop sets the rate.
// while the receiver stalls the core holds the current word and the
// queue fills, after which o_stall rises.
// synchronous active-low reset empties the queue and loads the initial
// hash values; no clearing pass is needed.
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int QUEUE_LOG2 = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_carries_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic cmd_valid, cmd_take;
    t_cmd cmd;

    sha_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_carries_byte,
        .i_is_last, .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_valid, .i_stall, .o_digest_word,
        .o_word_index, .o_last_word
    );
endmodule

// File: bench/tb_sha256_stream_hasher.sv
// self-checking testbench for the sha-256 stream hasher
`timescale 1ns / 100ps

module tb_sha256_stream_hasher
    import sha_pkg::*;
();

    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       is_last;
        bit         drain;
    } t_byte_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_carries_byte = 1'b0;
    logic        i_is_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_stream_hasher uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_byte_item  pending_items[$];
    t_digest_out expected_words[$];
    int          mismatches = 0;
    bit          stimulus_done = 0;
    int          idle_cycles = 0;

    // predictor state
    t_word      hash_h[8];
    logic [7:0] msg_buf[64];
    logic [63:0] msg_bits;
    int         fill_pos;

    function automatic t_word rotr(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress_buffer();
        t_word w[64];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_buf[4*t], msg_buf[4*t+1], msg_buf[4*t+2], msg_buf[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
        e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic open_message();
        for (int k = 0; k < 8; k++) hash_h[k] = INIT_HASH[k];
        msg_bits = '0;
        fill_pos = 0;
    endtask

    task automatic predict_digest(t_byte_item it);
        int p;
        t_digest_out d;
        if (it.carries_byte) begin
            msg_buf[fill_pos] = it.data_byte;
            msg_bits += 64'd8;
            fill_pos = (fill_pos + 1) % 64;
            if (fill_pos == 0) compress_buffer();
        end
        if (!it.is_last) return;
        p = fill_pos;
        msg_buf[p] = PAD_BYTE;
        p++;
        if (p > 56) begin
            while (p < 64) begin
                msg_buf[p] = 8'h00;
                p++;
            end
            compress_buffer();
            p = 0;
        end
        while (p < 56) begin
            msg_buf[p] = 8'h00;
            p++;
        end
        for (int k = 0; k < 8; k++) msg_buf[56+k] = msg_bits[8*(7-k) +: 8];
        compress_buffer();
        for (int k = 0; k < 8; k++) begin
            d.word = hash_h[k];
            d.index = k[2:0];
            d.last = (k == 7);
            expected_words = {expected_words, d};
        end
        open_message();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic add_item(logic [7:0] b, logic cb, logic last);
        t_byte_item it;
        it.data_byte = b; it.carries_byte = cb; it.is_last = last; it.drain = 0;
        pending_items = {pending_items, it};
    endtask

    task automatic add_message(int len, bit close_empty);
        for (int k = 0; k < len; k++)
            add_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !close_empty);
        if (close_empty || len == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // driver
    int   send_wait = 0;
    bit   draining = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_digest('{i_data_byte, i_carries_byte, i_is_last, 0});
            end
            if (!(i_valid && o_stall)) begin
                if (draining) begin
                    i_valid <= 1'b0;
                    if (expected_words.size() == 0) draining = 0;
                end else if (send_wait > 0) begin
                    i_valid <= 1'b0;
                    send_wait--;
                end else if (pending_items.size() > 0 && pending_items[0].drain) begin
                    void'(pending_items.pop_front());
                    i_valid <= 1'b0;
                    draining = 1;
                end else if (pending_items.size() > 0) begin
                    t_byte_item it;
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= it.data_byte;
                    i_carries_byte <= it.carries_byte;
                    i_is_last <= it.is_last;
                    send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
                end else begin
                    i_valid <= 1'b0;
                    stimulus_done = 1;
                end
            end
        end
    end

    // monitor and receiver stalls
    int recv_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_digest_word, 32'h0);
                end else begin
                    t_digest_out e;
                    e = expected_words.pop_front();
                    if (o_digest_word !== e.word)
                        report_mismatch("digest_word", o_digest_word, e.word);
                    if (o_word_index !== e.index)
                        report_mismatch("word_index", 32'(o_word_index), 32'(e.index));
                    if (o_last_word !== e.last)
                        report_mismatch("last_word", 32'(o_last_word), 32'(e.last));
                end
                recv_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
            end
            if (recv_wait > 0) begin
                i_stall <= 1'b1;
                recv_wait--;
            end else begin
                i_stall <= 1'b0;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_sha256_stream_hasher NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_byte_item pause;
        int total;
        pause.data_byte = 8'h00; pause.carries_byte = 0; pause.is_last = 0; pause.drain = 1;
        open_message();
        for (int k = 0; k < 64; k++) msg_buf[k] = 8'h00;
        // directed: empty message, ignored item, extremes, byte with last
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'h5a, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h55, 1'b1, 1'b0);
        add_item(8'haa, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        pending_items = {pending_items, pause};
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        // random: lengths around the padding and block edges
        total = 0;
        while (total < 230) begin
            int len;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(63, 65);
                3: len = $urandom_range(118, 121);
                default: len = $urandom_range(1, 20);
            endcase
            if (len > 230 - total) len = 230 - total;
            if ($urandom_range(0, 4) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_message(len, $urandom_range(0, 3) == 0);
            total += len + 1;
            if ($urandom_range(0, 5) == 0) pending_items = {pending_items, pause};
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_words.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_sha256_stream_hasher OK");
        end else begin
            $display("tb_sha256_stream_hasher NOT OK");
        end
        $finish;
    end
endmodule
